>>> rtl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Types, constants and helpers shared by the mip chain generator.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int CFG_W      = 13;    // width / height register width
  localparam int LEVEL_W    = 4;     // level field and level counters
  localparam int POS_W      = 13;    // internal column / row counters
  localparam int OUT_POS_W  = 12;    // col / row result fields
  localparam int CH_W       = 8;     // one color channel
  localparam int LANE_W     = 10;    // channel lane with headroom for 4-sums
  localparam int MAX_HEIGHT = 4096;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_LEVEL_COUNT  = 2'd2
  } reg_idx_e;

  // lane 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][LANE_W-1:0] lanes_t;

  typedef struct packed {
    lanes_t           px;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } item_t;

  // clamped geometry; the user must keep it stable while items are in flight (not enforced here)
  typedef struct packed {
    logic [CFG_W-1:0]   w;
    logic [CFG_W-1:0]   h;
    logic [LEVEL_W-1:0] levels;
  } geom_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_READ
  } back_state_e;

  function automatic lanes_t lane_add(lanes_t a, lanes_t b);
    lanes_t s;
    for (int i = 0; i < 4; i++) begin
      s[i] = a[i] + b[i];
    end
    return s;
  endfunction

  function automatic lanes_t quarter(lanes_t a);
    lanes_t q;
    for (int i = 0; i < 4; i++) begin
      q[i] = {2'b00, a[i][LANE_W-1:2]};
    end
    return q;
  endfunction

endpackage

>>> rtl/bfm_if.sv
// ----------------------------------------------------------------------------
// bfm interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bfm_pix_if
  import bfm_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface bfm_res_if
  import bfm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [LEVEL_W-1:0]   level;
  logic [OUT_POS_W-1:0] col;
  logic [OUT_POS_W-1:0] row;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic [CH_W-1:0]      out_alpha;
  logic                 last;
  modport source (output valid, level, col, row, out_red, out_green, out_blue,
                  out_alpha, last, input ready);
  modport sink   (input valid, level, col, row, out_red, out_green, out_blue,
                  out_alpha, last, output ready);
endinterface

interface bfm_cfg_if
  import bfm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       addr;
  logic [CFG_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> rtl/bfm_fifo.sv
// ----------------------------------------------------------------------------
// bfm_fifo
// Two-entry queue between the front and the cascade engine.
// ----------------------------------------------------------------------------
module bfm_fifo
  import bfm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_data_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/bfm_front.sv
// ----------------------------------------------------------------------------
// bfm_front
// Config registers, level-0 raster counters and item intake.
// ----------------------------------------------------------------------------
module bfm_front
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_LEVELS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfm_pix_if.sink   pix_i,
  bfm_cfg_if.sink   cfg_i,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output item_t     push_data_o,
  output geom_t     geom_o
);

  logic [CFG_W-1:0]   w_q, h_q;
  logic [LEVEL_W-1:0] lc_q;
  logic [POS_W-1:0]   col_q, row_q;
  logic               geom_ok, cfg_we, push;
  logic [POS_W-1:0]   col_inc, row_inc;

  assign geom_o.w      = (int'(w_q) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : w_q;
  assign geom_o.h      = (int'(h_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : h_q;
  assign geom_o.levels = (int'(lc_q) > MAX_LEVELS) ? LEVEL_W'(MAX_LEVELS) : lc_q;
  assign geom_ok = (geom_o.w != '0) && (geom_o.h != '0) && (geom_o.levels != '0);

  // a degenerate geometry swallows pixels
  assign pix_i.ready  = push_ready_i || !geom_ok;
  assign push_valid_o = pix_i.valid && geom_ok;
  assign push         = push_valid_o && push_ready_i;

  assign push_data_o.px  = {{2'b00, pix_i.alpha}, {2'b00, pix_i.blue},
                            {2'b00, pix_i.green}, {2'b00, pix_i.red}};
  assign push_data_o.col = col_q;
  assign push_data_o.row = row_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign col_inc     = col_q + POS_W'(1);
  assign row_inc     = row_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= CFG_W'(4096);
      h_q   <= CFG_W'(4096);
      lc_q  <= LEVEL_W'(12);
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_i.addr)
        REG_IMAGE_WIDTH: begin
          w_q   <= cfg_i.data;
          col_q <= '0;
          row_q <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          h_q   <= cfg_i.data;
          col_q <= '0;
          row_q <= '0;
        end
        REG_LEVEL_COUNT: begin
          lc_q  <= cfg_i.data[LEVEL_W-1:0];
          col_q <= '0;
          row_q <= '0;
        end
        default: ;
      endcase
    end else if (push) begin
      if (col_inc >= geom_o.w) begin
        col_q <= '0;
        row_q <= (row_inc >= geom_o.h) ? '0 : row_inc;
      end else begin
        col_q <= col_inc;
      end
    end
  end

endmodule

>>> rtl/bfm_back.sv
// ----------------------------------------------------------------------------
// bfm_back
// Cascade engine: emits level 0, then walks levels through pair holds
// and the shared line buffer, with a read step and an emit step per level.
// ----------------------------------------------------------------------------
module bfm_back
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_LEVELS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  item_t     pop_data_i,
  input  geom_t     geom_i,
  bfm_res_if.source res_o
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int IW    = ((AW > CFG_W) ? AW : CFG_W) + 1;
  localparam int PH_AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  back_state_e        state_q, state_d;
  lanes_t             px_q, pair_q;
  logic [POS_W-1:0]   c_q, r_q;
  logic [LEVEL_W-1:0] k_q, lev_q;
  logic [IW-1:0]      base_q;
  lanes_t             pair_hold_q [MAX_LEVELS];

  logic [4*LANE_W-1:0] line_mem [MAX_WIDTH];
  logic [4*LANE_W-1:0] rdata_q;

  logic               ov_q, out_last_q;
  logic [LEVEL_W-1:0] out_lev_q;
  logic [OUT_POS_W-1:0] out_col_q, out_row_q;
  lanes_t             out_px_q;

  logic [CFG_W-1:0] wk, hk;
  logic             go, in_buf, emits_next, out_free, fire;
  logic             hold_we, mem_we, rd_en;
  lanes_t           pair;
  logic [IW-1:0]    idx;

  assign out_free = !ov_q || res_o.ready;
  assign wk   = geom_i.w >> k_q;
  assign hk   = geom_i.h >> k_q;
  assign go   = (k_q < geom_i.levels) && ((c_q >> 1) < wk) && ((r_q >> 1) < hk);
  assign pair = lane_add(pair_hold_q[k_q[PH_AW-1:0]], px_q);
  assign idx  = base_q + IW'(c_q >> 1);
  assign in_buf     = idx < IW'(MAX_WIDTH);
  assign emits_next = go && c_q[0] && in_buf && r_q[0];

  assign fire    = (state_q == S_EMIT) && out_free;
  assign hold_we = fire && go && !c_q[0];
  assign mem_we  = fire && go && c_q[0] && in_buf && !r_q[0];
  assign rd_en   = fire && emits_next;
  assign pop_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (pop_valid_i) state_d = S_EMIT;
      S_EMIT: if (fire) state_d = emits_next ? S_READ : S_IDLE;
      S_READ: state_d = S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          px_q   <= pop_data_i.px;
          c_q    <= pop_data_i.col;
          r_q    <= pop_data_i.row;
          k_q    <= LEVEL_W'(1);
          lev_q  <= '0;
          base_q <= '0;
        end
      end
      S_EMIT: begin
        if (rd_en) pair_q <= pair;
      end
      S_READ: begin
        px_q   <= quarter(lane_add(rdata_q, pair_q));
        c_q    <= c_q >> 1;
        r_q    <= r_q >> 1;
        base_q <= base_q + IW'(wk);
        lev_q  <= k_q;
        k_q    <= k_q + LEVEL_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) pair_hold_q[i] <= '0;
    end else if (hold_we) begin
      pair_hold_q[k_q[PH_AW-1:0]] <= px_q;
    end
  end

  // line buffer of horizontal pair sums
  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[idx[AW-1:0]] <= pair;
    if (rd_en)  rdata_q <= line_mem[idx[AW-1:0]];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (fire) begin
      ov_q <= 1'b1;
    end else if (res_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_lev_q  <= lev_q;
      out_col_q  <= c_q[OUT_POS_W-1:0];
      out_row_q  <= r_q[OUT_POS_W-1:0];
      out_px_q   <= px_q;
      out_last_q <= !emits_next;
    end
  end

  assign res_o.valid     = ov_q;
  assign res_o.level     = out_lev_q;
  assign res_o.col       = out_col_q;
  assign res_o.row       = out_row_q;
  assign res_o.out_red   = out_px_q[0][CH_W-1:0];
  assign res_o.out_green = out_px_q[1][CH_W-1:0];
  assign res_o.out_blue  = out_px_q[2][CH_W-1:0];
  assign res_o.out_alpha = out_px_q[3][CH_W-1:0];
  assign res_o.last      = out_last_q;

  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_EMIT)
    else $error("read step not followed by emit");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.level < geom_i.levels)
    else $error("result level beyond level count");

  a_read_odd_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (c_q[0] && r_q[0] && !mem_we))
    else $error("line read outside odd row and column");

endmodule

>>> rtl/box_filter_mipmap_chain.sv
// ----------------------------------------------------------------------------
// box_filter_mipmap_chain
// Streaming mip chain generator, 2x2 truncating box filter per level.
// ----------------------------------------------------------------------------
//  channel | dir | modport     | payload
//  pix_i   | in  | bfm_pix_if  | red, green, blue, alpha
//  res_o   | out | bfm_res_if  | level, col, row, out_red..out_alpha, last
//  cfg_i   | in  | bfm_cfg_if  | addr (register index), data
//
//  An item passes the engine's idle and emit states, plus a read and emit step
//  per extra level done (line buffer read and sum); the engine sets the rate.
//  A two-entry queue lets the front take pixels while the engine works.
//  Reset (rst_ni low, async) restores 4096 x 4096 and 12 levels.
//  A stalled result register holds the engine; the queue then fills
//  and pix_i.ready drops. The line buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module box_filter_mipmap_chain
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_LEVELS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfm_pix_if.sink   pix_i,
  bfm_res_if.source res_o,
  bfm_cfg_if.sink   cfg_i
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_data, pop_data;
  geom_t geom;

  // intake: config, raster position, degenerate-geometry drop
  bfm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data),
    .geom_o       (geom)
  );

  bfm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // cascade: level 0 pass-through, then one level per step
  bfm_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .geom_i      (geom),
    .res_o       (res_o)
  );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the mip chain generator against a cycle-free model of the box
// filter cascade: directed geometry corners, then random frames under
// bursty input and stalling output, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench
  import bfm_pkg::*;
;

  localparam logic [1:0] REG_UNLISTED = 2'd3;   // index past the register list
  localparam int         DRAIN_CYCLES = 80;     // settling wait after all results
  localparam int         HOLD_CYCLES  = 300;    // long output hold-off
  localparam int         LINE_DEPTH   = 4096;
  localparam int         LEVEL_DEPTH  = 12;

  typedef struct {
    logic [LEVEL_W-1:0]   level;
    logic [OUT_POS_W-1:0] col;
    logic [OUT_POS_W-1:0] row;
    lanes_t               px;
    logic                 last;
  } mip_px_t;

  logic clk_i;
  logic rst_ni;

  bfm_pix_if pix ();
  bfm_res_if res ();
  bfm_cfg_if cfg ();

  box_filter_mipmap_chain uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // --------------------------------------------------------------------------
  // Model state: geometry registers, frame position, held pixels, line sums
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]   geom_width;
  logic [CFG_W-1:0]   geom_height;
  logic [LEVEL_W-1:0] geom_levels;
  int unsigned        frame_col;
  int unsigned        frame_row;
  lanes_t             even_col_px [LEVEL_DEPTH];
  lanes_t             row_pair_sums [LINE_DEPTH];

  mip_px_t expected_px[$];

  int fail_count;
  int pixels_sent;
  int results_seen;
  int frames_set;
  int burst_left;
  bit hold_req;
  bit hold_on;

  function automatic lanes_t add_lanes(lanes_t a, lanes_t b);
    lanes_t s;
    for (int i = 0; i < 4; i++) begin
      s[i] = a[i] + b[i];
    end
    return s;
  endfunction

  function automatic lanes_t div4_lanes(lanes_t a);
    lanes_t q;
    for (int i = 0; i < 4; i++) begin
      q[i] = a[i] >> 2;
    end
    return q;
  endfunction

  task automatic restart_frame();
    frame_col = 0;
    frame_row = 0;
    for (int k = 0; k < LEVEL_DEPTH; k++) begin
      even_col_px[k] = '0;
    end
  endtask

  // Model of one register write; the unlisted index leaves everything alone
  task automatic apply_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH:  geom_width  = val;
      REG_IMAGE_HEIGHT: geom_height = val;
      REG_LEVEL_COUNT:  geom_levels = val[LEVEL_W-1:0];
      default:          return;
    endcase
    restart_frame();
  endtask

  // Expected results of one accepted pixel, queued in level order
  task automatic predict_mips(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                              logic [7:0] a8);
    int unsigned w, h, lv, c, r, c0, r0, base, wk, hk, idx;
    lanes_t      px;
    lanes_t      pair;
    mip_px_t     held;
    w  = (geom_width  > LINE_DEPTH)  ? LINE_DEPTH  : geom_width;
    h  = (geom_height > MAX_HEIGHT)  ? MAX_HEIGHT  : geom_height;
    lv = (geom_levels > LEVEL_DEPTH) ? LEVEL_DEPTH : geom_levels;
    if (lv == 0 || w == 0 || h == 0) return;
    if (frame_col >= w || frame_row >= h) restart_frame();
    c  = frame_col;
    r  = frame_row;
    c0 = c;
    r0 = r;
    px[0] = {2'b00, r8};
    px[1] = {2'b00, g8};
    px[2] = {2'b00, b8};
    px[3] = {2'b00, a8};
    held = '{level: '0, col: OUT_POS_W'(c), row: OUT_POS_W'(r), px: px, last: 1'b0};
    base = 0;
    for (int k = 1; k < lv; k++) begin
      wk = w >> k;
      hk = h >> k;
      if ((c >> 1) >= wk || (r >> 1) >= hk) break;
      // even column: park it until its right neighbor shows up
      if (c % 2 == 0) begin
        even_col_px[k] = px;
        break;
      end
      pair = add_lanes(even_col_px[k], px);
      idx  = base + (c >> 1);
      if (idx >= LINE_DEPTH) break;
      // even row: store the pair sum for the odd row below
      if (r % 2 == 0) begin
        row_pair_sums[idx] = pair;
        break;
      end
      px = div4_lanes(add_lanes(row_pair_sums[idx], pair));
      c  = c >> 1;
      r  = r >> 1;
      expected_px.push_back(held);
      held = '{level: LEVEL_W'(k), col: OUT_POS_W'(c), row: OUT_POS_W'(r), px: px,
               last: 1'b0};
      base += wk;
    end
    held.last = 1'b1;
    expected_px.push_back(held);
    c0++;
    if (c0 >= w) begin
      c0 = 0;
      r0++;
    end
    if (r0 >= h) begin
      restart_frame();
    end else begin
      frame_col = c0;
      frame_row = r0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset, limit
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: stall mode redrawn at random from mode_cnt; hold_on forces a stall
  // --------------------------------------------------------------------------
  initial begin
    int mode_cnt;
    int mode;
    mode_cnt = 0;
    mode     = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      mode_cnt++;
      if (mode_cnt % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_on) begin
        res.ready <= 1'b0;
      end else begin
        case (mode)
          0:       res.ready <= 1'b1;                      // no stalls
          1:       res.ready <= ($urandom_range(0, 3) != 0);
          default: res.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // long hold-off, counted here so the sender keeps going meanwhile
  initial begin
    hold_on = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_on  = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on  = 1'b0;
      end
    end
  end

  // result checker: oldest expectation first
  always @(posedge clk_i) begin
    mip_px_t want;
    if (rst_ni && res.valid && res.ready) begin
      results_seen++;
      if (expected_px.size() == 0) begin
        fail_count++;
        $display("%0t: expected no result, actual L%0d (%0d,%0d)", $time,
                 res.level, res.col, res.row);
      end else begin
        want = expected_px.pop_front();
        if (res.level !== want.level || res.col !== want.col ||
            res.row !== want.row || res.out_red !== want.px[0][7:0] ||
            res.out_green !== want.px[1][7:0] || res.out_blue !== want.px[2][7:0] ||
            res.out_alpha !== want.px[3][7:0] || res.last !== want.last) begin
          fail_count++;
          $display("%0t: expected L%0d (%0d,%0d) rgba %h %h %h %h last %b", $time,
                   want.level, want.col, want.row, want.px[0][7:0], want.px[1][7:0],
                   want.px[2][7:0], want.px[3][7:0], want.last);
          $display("%0t:   actual L%0d (%0d,%0d) rgba %h %h %h %h last %b", $time,
                   res.level, res.col, res.row, res.out_red, res.out_green,
                   res.out_blue, res.out_alpha, res.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side; every task is entered and left on a rising edge
  // --------------------------------------------------------------------------
  task automatic send_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                            logic [7:0] a8);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix.valid <= 1'b1;
    pix.red   <= r8;
    pix.green <= g8;
    pix.blue  <= b8;
    pix.alpha <= a8;
    do @(posedge clk_i); while (!(pix.valid && pix.ready));
    pixels_sent++;
    predict_mips(r8, g8, b8, a8);
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // idle point: all results back, then time for any cascade still running
  task automatic drain();
    pix.valid <= 1'b0;
    burst_left = 0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.addr  <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!(cfg.valid && cfg.ready));
    apply_reg(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(int w, int h, int lv);
    drain();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    write_reg(REG_LEVEL_COUNT, CFG_W'(lv));
    frames_set++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset geometry is 4096 x 4096 x 12: first row gives level-0 only
  task automatic test_reset_geometry();
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    send_pixel(8'haa, 8'h55, 8'h0f, 8'hf0);
    send_random_pixel();
  endtask

  // smallest full cascades, truncation at the top of the range, odd edges
  task automatic test_small_frames();
    set_geometry(2, 2, 2);
    send_pixel(8'hff, 8'hff, 8'h00, 8'h01);
    send_pixel(8'hff, 8'hff, 8'h00, 8'h01);
    send_pixel(8'hff, 8'hfe, 8'h00, 8'h01);
    send_pixel(8'hfe, 8'hfe, 8'h03, 8'h00);
    // 3 x 3 with level count above the maximum: odd row and column unused
    set_geometry(3, 3, 15);
    repeat (9) send_random_pixel();
  endtask

  // zero level count, width or height: pixels are ignored
  task automatic test_empty_geometry();
    set_geometry(4, 4, 0);
    repeat (2) send_random_pixel();
    set_geometry(0, 4, 3);
    send_random_pixel();
    set_geometry(4, 0, 3);
    send_random_pixel();
  endtask

  // oversized width/height clamp; an unlisted index must not restart the frame
  task automatic test_clamp_and_unlisted();
    set_geometry(8191, 8191, 15);
    repeat (3) send_random_pixel();
    set_geometry(2, 4, 2);
    repeat (3) send_random_pixel();
    drain();
    write_reg(REG_UNLISTED, 13'h1fff);
    repeat (5) send_random_pixel();
  endtask

  // long output hold-off while a full 8 x 8 frame keeps coming
  task automatic test_output_holdoff();
    set_geometry(8, 8, 4);
    hold_req = 1'b1;
    repeat (64) send_random_pixel();
  endtask

  // random frames: mostly complete, small, some deep; a few cut short
  task automatic test_random_frames();
    int w, h, lv, n, stop_at;
    stop_at = pixels_sent + 260;
    while (pixels_sent < stop_at) begin
      case ($urandom_range(0, 5))
        0: begin w = 16; h = $urandom_range(1, 16); end
        1: begin w = $urandom_range(1, 32); h = $urandom_range(1, 4); end
        default: begin w = $urandom_range(1, 10); h = $urandom_range(1, 10); end
      endcase
      lv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 6);
      set_geometry(w, h, lv);
      n = w * h;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);  // broken frame
      if (lv == 0) n = 3;
      // keep the total near the planned item count
      if (pixels_sent + n > stop_at) n = stop_at - pixels_sent;
      repeat (n) send_random_pixel();
      // sometimes run into a second frame without reconfiguring
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2 * w)) send_random_pixel();
    end
  endtask

  initial begin
    fail_count   = 0;
    pixels_sent  = 0;
    results_seen = 0;
    frames_set   = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    geom_width   = 13'd4096;
    geom_height  = 13'd4096;
    geom_levels  = 4'd12;
    restart_frame();
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    pix.alpha <= '0;
    cfg.valid <= 1'b0;
    cfg.addr  <= '0;
    cfg.data  <= '0;
    rst_ni     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_small_frames();
    test_empty_geometry();
    test_clamp_and_unlisted();
    test_output_holdoff();
    test_random_frames();
    drain();

    $display("Sent %0d pixels over %0d geometry settings, checked %0d results.",
             pixels_sent, frames_set, results_seen);
    $display("Covered clamped, empty and odd geometries and a long output stall.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bfm_pkg.sv
rtl/bfm_if.sv
rtl/bfm_fifo.sv
rtl/bfm_front.sv
rtl/bfm_back.sv
rtl/box_filter_mipmap_chain.sv
tb/testbench.sv
